>>> hw/rtl/scrolling_text_marquee_unit_defines.svh
// assertion macros for the scrolling text marquee unit
// used by the rtl files that carry concurrent checks; no other dependencies
`ifndef SCROLLING_TEXT_MARQUEE_UNIT_DEFINES_SVH
`define SCROLLING_TEXT_MARQUEE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SMQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("smq assertion failed");
`define SMQ_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("smq implication failed");
`else
`define SMQ_ASSERT(label, clk, rst_n, prop)
`define SMQ_ASSERT_IMPLY(label, clk, rst_n, cond, expr)
`endif
`endif

>>> hw/rtl/smq_pkg.sv
// shared types, constants and font functions for the scrolling text marquee
// no dependencies
`timescale 1ns / 1ps

package smq_pkg;

    localparam int MAX_CHARS_DEFAULT = 16;
    localparam int PIX_W             = 64;
    localparam int WIDTH_W           = 7;
    localparam int POS_W             = 7;
    localparam int ROW_IDX_W         = 3;
    localparam int GLYPH_W           = 5;
    localparam int CODE_W            = 3;
    localparam int PERIOD_W          = 16;
    localparam int DIR_W             = 2;
    localparam int CMD_W             = 2;
    localparam int CHAR_W            = 8;
    localparam int CFG_IDX_W         = 1;
    localparam int CFG_DATA_W        = 16;
    localparam int NUM_ROWS          = 5;
    localparam int GLYPH_COUNT       = 29;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd2;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_DIRECTION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_PERIOD      = 1'b1;

    localparam logic [GLYPH_W-1:0] GLYPH_BANG  = 5'd26;
    localparam logic [GLYPH_W-1:0] GLYPH_QUERY = 5'd27;
    localparam logic [GLYPH_W-1:0] GLYPH_BLANK = 5'd28;

    localparam logic [ROW_IDX_W-1:0] LAST_ROW_IDX = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [CHAR_W-1:0] char_code;
    } item_t;

    typedef struct packed {
        logic [ROW_IDX_W-1:0] row_index;
        logic [PIX_W-1:0]     row_pixels;
        logic [WIDTH_W-1:0]   row_width;
        logic                 last_row;
    } result_t;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_FRAME  = 2'd2
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [GLYPH_W-1:0] glyph;
    } job_t;

    // row codes per glyph, top row in the upper bits
    localparam logic [14:0] FONT [GLYPH_COUNT] = '{
        {3'd7, 3'd5, 3'd7, 3'd5, 3'd5}, {3'd7, 3'd5, 3'd4, 3'd5, 3'd7},
        {3'd7, 3'd1, 3'd1, 3'd1, 3'd7}, {3'd4, 3'd5, 3'd5, 3'd5, 3'd4},
        {3'd7, 3'd1, 3'd7, 3'd1, 3'd7}, {3'd7, 3'd1, 3'd7, 3'd1, 3'd1},
        {3'd7, 3'd1, 3'd5, 3'd5, 3'd7}, {3'd5, 3'd5, 3'd7, 3'd5, 3'd5},
        {3'd2, 3'd2, 3'd2, 3'd2, 3'd2}, {3'd3, 3'd3, 3'd3, 3'd3, 3'd4},
        {3'd5, 3'd5, 3'd4, 3'd5, 3'd5}, {3'd1, 3'd1, 3'd1, 3'd1, 3'd7},
        {3'd5, 3'd7, 3'd7, 3'd5, 3'd5}, {3'd5, 3'd5, 3'd7, 3'd5, 3'd5},
        {3'd7, 3'd5, 3'd5, 3'd5, 3'd7}, {3'd7, 3'd5, 3'd7, 3'd1, 3'd1},
        {3'd7, 3'd5, 3'd5, 3'd7, 3'd3}, {3'd7, 3'd5, 3'd4, 3'd5, 3'd5},
        {3'd7, 3'd1, 3'd7, 3'd3, 3'd7}, {3'd7, 3'd2, 3'd2, 3'd2, 3'd2},
        {3'd5, 3'd5, 3'd5, 3'd5, 3'd7}, {3'd5, 3'd5, 3'd5, 3'd5, 3'd2},
        {3'd5, 3'd5, 3'd7, 3'd7, 3'd5}, {3'd5, 3'd5, 3'd2, 3'd5, 3'd5},
        {3'd5, 3'd5, 3'd7, 3'd3, 3'd7}, {3'd7, 3'd3, 3'd2, 3'd1, 3'd7},
        {3'd2, 3'd2, 3'd2, 3'd0, 3'd2}, {3'd7, 3'd3, 3'd2, 3'd0, 3'd1},
        {3'd0, 3'd0, 3'd0, 3'd0, 3'd0}
    };

    function automatic logic [GLYPH_W-1:0] glyph_of(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] u;
        u = c;
        if (c inside {[8'h61:8'h7A]})
        begin
            u = c - 8'd32;
        end
        if (u inside {[8'h41:8'h5A]})
        begin
            return GLYPH_W'(u - 8'h41);
        end
        else if (u == 8'h21)
        begin
            return GLYPH_BANG;
        end
        else if (u == 8'h3F)
        begin
            return GLYPH_QUERY;
        end
        return GLYPH_BLANK;
    endfunction

    function automatic logic [CODE_W-1:0] font_code(input logic [GLYPH_W-1:0] g,
                                                    input logic [ROW_IDX_W-1:0] row);
        logic [14:0] e;
        e = (g < GLYPH_W'(GLYPH_COUNT)) ? FONT[g] : '0;
        case (row)
            3'd0:    return e[14:12];
            3'd1:    return e[11:9];
            3'd2:    return e[8:6];
            3'd3:    return e[5:3];
            3'd4:    return e[2:0];
            default: return '0;
        endcase
    endfunction

    // row code to lit glyph columns, leftmost column in bit 0
    function automatic logic [CODE_W-1:0] code_columns(input logic [CODE_W-1:0] code);
        case (code)
            3'd3:    return 3'd4;
            3'd4:    return 3'd3;
            default: return code;
        endcase
    endfunction

endpackage

>>> hw/rtl/smq_queue.sv
// short job queue between the marquee front and back ends
// depends on smq_pkg
`timescale 1ns / 1ps

module smq_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  smq_pkg::job_t wdata,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output smq_pkg::job_t rdata
);

    localparam int DEPTH = smq_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    smq_pkg::job_t    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hw/rtl/smq_front.sv
// marquee front end: takes transactions, folds characters, divides ticks
// depends on smq_pkg; feeds smq_queue
`timescale 1ns / 1ps

module smq_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  smq_pkg::item_t                 item,
    output logic                           full,
    input  logic [smq_pkg::PERIOD_W-1:0]   step_period,
    input  logic                           q_full,
    output logic                           q_push,
    output smq_pkg::job_t                  q_wdata
);

    logic [smq_pkg::PERIOD_W-1:0] div_reg;
    logic [smq_pkg::PERIOD_W-1:0] div_next;
    logic [smq_pkg::PERIOD_W-1:0] div_inc;
    logic [smq_pkg::PERIOD_W-1:0] period_eff;
    logic                         accept;

    assign full       = q_full;
    assign accept     = push && !q_full;
    assign div_inc    = div_reg + 1'b1;
    assign period_eff = (step_period == '0) ? smq_pkg::PERIOD_W'(1) : step_period;

    always_comb
    begin
        div_next        = div_reg;
        q_push          = 1'b0;
        q_wdata.op      = smq_pkg::OP_CLEAR;
        q_wdata.glyph   = smq_pkg::glyph_of(item.char_code);
        if (accept)
        begin
            case (item.command)
                smq_pkg::CMD_CLEAR:
                begin
                    div_next   = '0;
                    q_push     = 1'b1;
                    q_wdata.op = smq_pkg::OP_CLEAR;
                end
                smq_pkg::CMD_APPEND:
                begin
                    q_push     = 1'b1;
                    q_wdata.op = smq_pkg::OP_APPEND;
                end
                smq_pkg::CMD_TICK:
                begin
                    if (div_inc >= period_eff)
                    begin
                        div_next   = '0;
                        q_push     = 1'b1;
                        q_wdata.op = smq_pkg::OP_FRAME;
                    end
                    else
                    begin
                        div_next = div_inc;
                    end
                end
                default:
                begin
                    div_next = div_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg <= '0;
        end
        else
        begin
            div_reg <= div_next;
        end
    end

endmodule

>>> hw/rtl/smq_back.sv
// marquee back end: glyph buffer, scroll position and row generation
// depends on smq_pkg and the assertion macros header; drains smq_queue
`timescale 1ns / 1ps
`include "scrolling_text_marquee_unit_defines.svh"

module smq_back #(
    parameter int MAX_CHARS = smq_pkg::MAX_CHARS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  smq_pkg::job_t               q_data,
    output logic                        q_pop,
    input  logic [smq_pkg::DIR_W-1:0]   scroll_direction,
    output logic                        empty,
    input  logic                        pop,
    output smq_pkg::result_t            result
);

    localparam int LEN_W = $clog2(MAX_CHARS + 1);
    localparam int IDX_W = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
    localparam int POS_W = smq_pkg::POS_W;
    localparam int PIX_W = smq_pkg::PIX_W;
    localparam int WID_W = smq_pkg::WIDTH_W;
    localparam int RI_W  = smq_pkg::ROW_IDX_W;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_REDUCE = 3'b010,
        S_EMIT   = 3'b100
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic [smq_pkg::GLYPH_W-1:0]   glyph_reg [MAX_CHARS];
    logic                          glyph_we;
    logic [LEN_W-1:0]              len_reg;
    logic [LEN_W-1:0]              len_next;
    logic [POS_W-1:0]              sp_reg;
    logic [POS_W-1:0]              sp_next;
    logic [POS_W-1:0]              pos_reg;
    logic [POS_W-1:0]              pos_next;
    logic [WID_W-1:0]              rot_reg;
    logic [WID_W-1:0]              rot_next;
    logic [RI_W-1:0]               row_reg;
    logic [RI_W-1:0]               row_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    smq_pkg::result_t              result_reg;
    smq_pkg::result_t              result_next;

    logic [WID_W-1:0]              width;
    logic [WID_W-1:0]              modulus;
    logic                          dir_lr;
    logic [13:0]                   mul5;
    logic [4:0]                    quot5;
    logic [POS_W-1:0]              rem5;
    logic [WID_W-1:0]              lr_amt;
    logic [3:0]                    sel_sum;
    logic [RI_W-1:0]               sel_row;
    logic [PIX_W-1:0]              src_row;
    logic [PIX_W-1:0]              rot_row;
    logic [PIX_W-1:0]              width_mask;
    logic                          emit_go;

    assign width   = WID_W'({len_reg, 2'b00});
    assign modulus = width + 1'b1;
    assign dir_lr  = (scroll_direction == smq_pkg::DIR_LEFT)
                  || (scroll_direction == smq_pkg::DIR_RIGHT);
    assign emit_go = (state_reg == S_EMIT) && (!out_valid_reg || pop);
    assign empty   = !out_valid_reg;
    assign result  = result_reg;

    // position mod 5 by reciprocal, exact for 7 bit values
    assign mul5  = 14'(pos_reg) * 14'd103;
    assign quot5 = mul5[13:9];
    assign rem5  = pos_reg - 7'({2'b00, quot5}) * 7'd5;

    // pos is at most width here
    always_comb
    begin
        lr_amt = (pos_reg == width) ? '0 : pos_reg;
        if (scroll_direction == smq_pkg::DIR_RIGHT && lr_amt != '0)
        begin
            lr_amt = width - lr_amt;
        end
    end

    always_comb
    begin
        sel_sum = {1'b0, row_reg};
        if (scroll_direction == smq_pkg::DIR_UP)
        begin
            sel_sum = {1'b0, row_reg} + pos_reg[3:0];
        end
        else if (scroll_direction == smq_pkg::DIR_DOWN)
        begin
            sel_sum = {1'b0, row_reg} + 4'd5 - pos_reg[3:0];
        end
        if (sel_sum >= 4'd5)
        begin
            sel_sum = sel_sum - 4'd5;
        end
        sel_row = sel_sum[RI_W-1:0];
    end

    always_comb
    begin
        src_row = '0;
        for (int i = 0; i < MAX_CHARS; i++)
        begin
            if (LEN_W'(i) < len_reg)
            begin
                src_row[4*i +: 4] = {1'b0, smq_pkg::code_columns(
                    smq_pkg::font_code(glyph_reg[i], sel_row))};
            end
        end
    end

    assign width_mask = ~({PIX_W{1'b1}} << width);
    assign rot_row    = ((src_row >> rot_reg) | (src_row << (width - rot_reg))) & width_mask;

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        sp_next        = sp_reg;
        pos_next       = pos_reg;
        rot_next       = rot_reg;
        row_next       = row_reg;
        glyph_we       = 1'b0;
        q_pop          = 1'b0;
        out_valid_next = out_valid_reg && !pop;
        result_next    = result_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    case (q_data.op)
                        smq_pkg::OP_CLEAR:
                        begin
                            len_next = '0;
                            sp_next  = '0;
                        end
                        smq_pkg::OP_APPEND:
                        begin
                            if (len_reg < LEN_W'(MAX_CHARS))
                            begin
                                glyph_we = 1'b1;
                                len_next = len_reg + 1'b1;
                            end
                        end
                        smq_pkg::OP_FRAME:
                        begin
                            pos_next   = sp_reg;
                            state_next = S_REDUCE;
                        end
                        default:
                        begin
                            len_next = len_reg;
                        end
                    endcase
                end
            end
            S_REDUCE:
            begin
                row_next = '0;
                if (!dir_lr)
                begin
                    pos_next   = rem5;
                    rot_next   = '0;
                    state_next = S_EMIT;
                end
                else if (width == '0)
                begin
                    pos_next   = '0;
                    rot_next   = '0;
                    state_next = S_EMIT;
                end
                else if (pos_reg >= modulus)
                begin
                    pos_next = pos_reg - modulus;
                end
                else
                begin
                    rot_next   = lr_amt;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit_go)
                begin
                    out_valid_next         = 1'b1;
                    result_next.row_index  = row_reg;
                    result_next.row_pixels = dir_lr ? rot_row : src_row;
                    result_next.row_width  = width;
                    result_next.last_row   = (row_reg == smq_pkg::LAST_ROW_IDX);
                    row_next               = row_reg + 1'b1;
                    if (row_reg == smq_pkg::LAST_ROW_IDX)
                    begin
                        row_next   = '0;
                        sp_next    = pos_reg + 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (glyph_we)
        begin
            glyph_reg[len_reg[IDX_W-1:0]] <= q_data.glyph;
        end
        pos_reg    <= pos_next;
        rot_reg    <= rot_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            sp_reg        <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            sp_reg        <= sp_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `SMQ_ASSERT_IMPLY(a_last_row_flag, clk, rst_n, out_valid_reg,
        result_reg.last_row == (result_reg.row_index == smq_pkg::LAST_ROW_IDX))
    `SMQ_ASSERT_IMPLY(a_pos_reduced, clk, rst_n, (state_reg == S_EMIT),
        (dir_lr && pos_reg <= width) || (!dir_lr && pos_reg < 7'd5))
    `SMQ_ASSERT(a_frame_done, clk, rst_n,
        (emit_go && row_reg == smq_pkg::LAST_ROW_IDX) |=>
            (state_reg == S_IDLE && sp_reg == POS_W'($past(pos_reg) + 1'b1)))

endmodule

>>> hw/rtl/scrolling_text_marquee_unit.sv
// top level of the scrolling text marquee: configuration registers and wiring
// depends on smq_pkg, smq_front, smq_queue and smq_back
`timescale 1ns / 1ps

// usage
// input channel: push/full carries item (command, char_code). clear and append
// each queue a job straight from the front end; a tick only counts unless it
// ends a step period, in which case it queues a frame job.
// result channel: empty/pop carries result (row_index, row_pixels, row_width,
// last_row). each frame gives five rows, top row first, last_row on the fifth.
// a frame job passes from the job queue to the back end, which takes it in idle,
// reduces the scroll position in its reduce state (for left or right scrolling
// by subtract steps of width + 1) and emits the rows; rows follow one per cycle
// while pop keeps the output register free.
// a two entry job queue sits between front and back end; the input stalls
// (full) only when it is filled, and the back end holds a row in its output
// register while pop stays low, stopping row generation until it is taken.
// configuration: cfg_write/cfg_index/cfg_data, index 0 scroll_direction,
// index 1 step_period; write only while idle.
// reset clears text length, scroll position, tick divider, the job queue and
// the output valid flag; the glyph buffer is kept and read only after appends.

module scrolling_text_marquee_unit #(
    parameter int MAX_CHARS = smq_pkg::MAX_CHARS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  smq_pkg::item_t                    item,
    output logic                              empty,
    input  logic                              pop,
    output smq_pkg::result_t                  result,
    input  logic                              cfg_write,
    input  logic [smq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [smq_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [smq_pkg::DIR_W-1:0]    dir_reg;
    logic [smq_pkg::DIR_W-1:0]    dir_next;
    logic [smq_pkg::PERIOD_W-1:0] period_reg;
    logic [smq_pkg::PERIOD_W-1:0] period_next;

    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;
    smq_pkg::job_t q_wdata;
    smq_pkg::job_t q_rdata;

    always_comb
    begin
        dir_next    = dir_reg;
        period_next = period_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                smq_pkg::CFG_SCROLL_DIRECTION: dir_next    = cfg_data[smq_pkg::DIR_W-1:0];
                smq_pkg::CFG_STEP_PERIOD:      period_next = cfg_data[smq_pkg::PERIOD_W-1:0];
                default:                       dir_next    = dir_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg    <= smq_pkg::DIR_LEFT;
            period_reg <= smq_pkg::PERIOD_W'(1);
        end
        else
        begin
            dir_reg    <= dir_next;
            period_reg <= period_next;
        end
    end

    smq_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .item        (item),
        .full        (full),
        .step_period (period_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_wdata     (q_wdata)
    );

    smq_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .empty (q_empty),
        .rdata (q_rdata)
    );

    smq_back #(
        .MAX_CHARS (MAX_CHARS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .q_data           (q_rdata),
        .q_pop            (q_pop),
        .scroll_direction (dir_reg),
        .empty            (empty),
        .pop              (pop),
        .result           (result)
    );

endmodule

>>> dv/tb_top.sv
// self-checking testbench for scrolling_text_marquee_unit: random and directed text, ticks
// and register settings, every row checked against an in-bench marquee predictor
// depends on smq_pkg and the rtl of scrolling_text_marquee_unit
`timescale 1ns / 1ps

module tb_top;

    localparam logic [smq_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int TEXT_SLOTS    = 16;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 200;
    localparam int IDLE_PCT      = 32;

    // row codes per glyph, top row first
    localparam logic [2:0] GLYPH_ROWS [29][5] = '{
        '{7, 5, 7, 5, 5}, '{7, 5, 4, 5, 7}, '{7, 1, 1, 1, 7}, '{4, 5, 5, 5, 4},
        '{7, 1, 7, 1, 7}, '{7, 1, 7, 1, 1}, '{7, 1, 5, 5, 7}, '{5, 5, 7, 5, 5},
        '{2, 2, 2, 2, 2}, '{3, 3, 3, 3, 4}, '{5, 5, 4, 5, 5}, '{1, 1, 1, 1, 7},
        '{5, 7, 7, 5, 5}, '{5, 5, 7, 5, 5}, '{7, 5, 5, 5, 7}, '{7, 5, 7, 1, 1},
        '{7, 5, 5, 7, 3}, '{7, 5, 4, 5, 5}, '{7, 1, 7, 3, 7}, '{7, 2, 2, 2, 2},
        '{5, 5, 5, 5, 7}, '{5, 5, 5, 5, 2}, '{5, 5, 7, 7, 5}, '{5, 5, 2, 5, 5},
        '{5, 5, 7, 3, 7}, '{7, 3, 2, 1, 7}, '{2, 2, 2, 0, 2}, '{7, 3, 2, 0, 1},
        '{0, 0, 0, 0, 0}
    };
    // row code to lit columns, leftmost column in bit 0
    localparam logic [2:0] LIT_COLUMNS [8] = '{0, 1, 2, 4, 3, 5, 6, 7};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    smq_pkg::item_t item = '0;
    logic empty;
    logic pop = 1'b0;
    smq_pkg::result_t result;
    logic cfg_write = 1'b0;
    logic [smq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [smq_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    smq_pkg::item_t pending[$];
    smq_pkg::result_t rows_due[$];
    int mismatch_count = 0;
    bit offer_taken = 1'b0;
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    bit hold_used = 1'b0;
    int hold_left = 0;

    // predictor state
    logic [smq_pkg::GLYPH_W-1:0] glyphs [TEXT_SLOTS];
    int text_len = 0;
    int scroll_pos = 0;
    int tick_div = 0;
    logic [smq_pkg::DIR_W-1:0] scroll_dir = smq_pkg::DIR_LEFT;
    int step_per = 1;

    scrolling_text_marquee_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic logic [smq_pkg::GLYPH_W-1:0] glyph_for(logic [7:0] c);
        logic [7:0] up;
        up = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
        if (up >= 8'h41 && up <= 8'h5A)
        begin
            return smq_pkg::GLYPH_W'(up - 8'h41);
        end
        if (up == 8'h21)
        begin
            return smq_pkg::GLYPH_BANG;
        end
        if (up == 8'h3F)
        begin
            return smq_pkg::GLYPH_QUERY;
        end
        return smq_pkg::GLYPH_BLANK;
    endfunction

    function automatic logic [63:0] text_row(int r);
        logic [63:0] bits;
        bits = '0;
        for (int i = 0; i < text_len; i++)
        begin
            bits[4*i +: 3] = LIT_COLUMNS[GLYPH_ROWS[glyphs[i]][r]];
        end
        return bits;
    endfunction

    // displayed column d shows source column (d + amt) mod w
    function automatic logic [63:0] spin_row(logic [63:0] src, int w, int amt);
        logic [63:0] o;
        o = '0;
        for (int d = 0; d < w; d++)
        begin
            o[d] = src[(d + amt) % w];
        end
        return o;
    endfunction

    function automatic void marquee_step(smq_pkg::item_t it);
        int per;
        int width;
        int pos;
        smq_pkg::result_t row;
        case (it.command)
            smq_pkg::CMD_CLEAR:
            begin
                text_len = 0;
                scroll_pos = 0;
                tick_div = 0;
            end
            smq_pkg::CMD_APPEND:
            begin
                if (text_len < TEXT_SLOTS)
                begin
                    glyphs[text_len] = glyph_for(it.char_code);
                    text_len++;
                end
            end
            smq_pkg::CMD_TICK:
            begin
                per = (step_per == 0) ? 1 : step_per;
                tick_div = (tick_div + 1) & 16'hFFFF;
                if (tick_div >= per)
                begin
                    tick_div = 0;
                    width = 4 * text_len;
                    if (scroll_dir == smq_pkg::DIR_LEFT || scroll_dir == smq_pkg::DIR_RIGHT)
                    begin
                        pos = scroll_pos % (width + 1);
                    end
                    else
                    begin
                        pos = scroll_pos % 5;
                    end
                    for (int r = 0; r < smq_pkg::NUM_ROWS; r++)
                    begin
                        row.row_index = smq_pkg::ROW_IDX_W'(r);
                        row.row_width = smq_pkg::WIDTH_W'(width);
                        row.last_row = (r == smq_pkg::NUM_ROWS - 1);
                        case (scroll_dir)
                            smq_pkg::DIR_LEFT:
                            begin
                                row.row_pixels = (width == 0) ? '0 :
                                    spin_row(text_row(r), width, pos % width);
                            end
                            smq_pkg::DIR_RIGHT:
                            begin
                                row.row_pixels = (width == 0) ? '0 :
                                    spin_row(text_row(r), width,
                                             (width - pos % width) % width);
                            end
                            smq_pkg::DIR_UP:
                            begin
                                row.row_pixels = text_row((r + pos) % 5);
                            end
                            default:
                            begin
                                row.row_pixels = text_row((r + 5 - pos) % 5);
                            end
                        endcase
                        rows_due.push_back(row);
                    end
                    scroll_pos = (pos + 1) & 8'h7F;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t ns: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
        end
    endfunction

    // input side: acceptance and prediction, result side: checking
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            offer_taken <= push && !full;
            if (push && !full)
            begin
                marquee_step(item);
            end
            if (pop && !empty)
            begin
                if (rows_due.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t ns: row expected none actual row_index %0d pixels 0x%0h",
                             $time, result.row_index, result.row_pixels);
                end
                else
                begin
                    check_field("row_index", rows_due[0].row_index, result.row_index);
                    check_field("row_pixels", rows_due[0].row_pixels, result.row_pixels);
                    check_field("row_width", rows_due[0].row_width, result.row_width);
                    check_field("last_row", rows_due[0].last_row, result.last_row);
                    void'(rows_due.pop_front());
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            item <= '0;
        end
        else if (!push || offer_taken)
        begin
            if (pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                push <= 1'b1;
                item <= pending.pop_front();
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            pop <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_used)
        begin
            pop <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
        else
        begin
            pop <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic write_reg(logic [smq_pkg::CFG_IDX_W-1:0] idx,
                             logic [smq_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == smq_pkg::CFG_SCROLL_DIRECTION)
        begin
            scroll_dir = data[smq_pkg::DIR_W-1:0];
        end
        else
        begin
            step_per = data;
        end
    endtask

    task automatic queue_item(logic [smq_pkg::CMD_W-1:0] cmd, logic [7:0] c);
        smq_pkg::item_t it;
        it.command = cmd;
        it.char_code = c;
        pending.push_back(it);
    endtask

    task automatic settle();
        do
        begin
            @(posedge clk);
        end
        while (pending.size() != 0 || push || rows_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mostly appends and ticks with random text, some clears and unused commands
    task automatic run_phase(logic [smq_pkg::DIR_W-1:0] dir, int period, int count);
        int k;
        logic [smq_pkg::CMD_W-1:0] cmd;
        logic [7:0] c;
        write_reg(smq_pkg::CFG_SCROLL_DIRECTION, smq_pkg::CFG_DATA_W'(dir));
        write_reg(smq_pkg::CFG_STEP_PERIOD, smq_pkg::CFG_DATA_W'(period));
        repeat (count)
        begin
            k = $urandom_range(99);
            if (k < 4)
            begin
                cmd = smq_pkg::CMD_CLEAR;
            end
            else if (k < 8)
            begin
                cmd = CMD_UNUSED;
            end
            else if (k < 45)
            begin
                cmd = smq_pkg::CMD_APPEND;
            end
            else
            begin
                cmd = smq_pkg::CMD_TICK;
            end
            k = $urandom_range(9);
            if (cmd != smq_pkg::CMD_APPEND || k >= 8)
            begin
                c = 8'($urandom_range(255));
            end
            else if (k < 4)
            begin
                c = 8'h41 + 8'($urandom_range(25));
            end
            else if (k < 7)
            begin
                c = 8'h61 + 8'($urandom_range(25));
            end
            else
            begin
                c = $urandom_range(1) ? 8'h21 : 8'h3F;
            end
            queue_item(cmd, c);
        end
        settle();
    endtask

    initial
    begin
        #(2_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_reg(smq_pkg::CFG_SCROLL_DIRECTION, smq_pkg::CFG_DATA_W'(smq_pkg::DIR_LEFT));
        write_reg(smq_pkg::CFG_STEP_PERIOD, 16'd1);
        // empty text frame, unused command, every glyph class, full buffer, clear
        queue_item(smq_pkg::CMD_TICK, 8'h00);
        queue_item(CMD_UNUSED, 8'hFF);
        foreach (pending[i])
        begin
        end
        queue_item(smq_pkg::CMD_APPEND, 8'h41);
        queue_item(smq_pkg::CMD_APPEND, 8'h7A);
        queue_item(smq_pkg::CMD_APPEND, 8'h21);
        queue_item(smq_pkg::CMD_APPEND, 8'h3F);
        queue_item(smq_pkg::CMD_APPEND, 8'h20);
        queue_item(smq_pkg::CMD_APPEND, 8'h00);
        queue_item(smq_pkg::CMD_APPEND, 8'hFF);
        queue_item(smq_pkg::CMD_APPEND, 8'h40);
        queue_item(smq_pkg::CMD_APPEND, 8'h5B);
        queue_item(smq_pkg::CMD_APPEND, 8'h60);
        queue_item(smq_pkg::CMD_APPEND, 8'h7B);
        queue_item(smq_pkg::CMD_APPEND, 8'h61);
        queue_item(smq_pkg::CMD_APPEND, 8'h5A);
        queue_item(smq_pkg::CMD_APPEND, 8'h4D);
        queue_item(smq_pkg::CMD_APPEND, 8'h57);
        queue_item(smq_pkg::CMD_APPEND, 8'h51);
        queue_item(smq_pkg::CMD_APPEND, 8'h42);
        queue_item(smq_pkg::CMD_TICK, 8'hFF);
        queue_item(smq_pkg::CMD_TICK, 8'h00);
        queue_item(smq_pkg::CMD_TICK, 8'h55);
        queue_item(smq_pkg::CMD_CLEAR, 8'hAA);
        queue_item(smq_pkg::CMD_TICK, 8'h00);
        settle();

        run_phase(smq_pkg::DIR_RIGHT, 1, 30);
        run_phase(smq_pkg::DIR_UP, 2, 30);
        run_phase(smq_pkg::DIR_DOWN, 1, 30);
        run_phase(smq_pkg::DIR_LEFT, 0, 30);
        run_phase(smq_pkg::DIR_RIGHT, 3, 30);
        calm = 1'b1;
        run_phase(smq_pkg::DIR_UP, 1, 30);
        calm = 1'b0;
        hold_req = 1'b1;
        run_phase(smq_pkg::DIR_DOWN, 1, 40);
        run_phase(smq_pkg::DIR_LEFT, 65535, 15);
        run_phase(smq_pkg::DIR_UP, 1, 30);
        run_phase(smq_pkg::DIR_RIGHT, 2, 20);

        if (mismatch_count == 0 && rows_due.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/smq_pkg.sv
hw/rtl/smq_queue.sv
hw/rtl/smq_front.sv
hw/rtl/smq_back.sv
hw/rtl/scrolling_text_marquee_unit.sv
dv/tb_top.sv
